// ===== hdl/bpa_pkg.sv =====
// Shared types and constants for the bitmap page allocator.
// No dependencies; imported by every file in the project except bpa_ram and bpa_fifo.
package bpa_pkg;

	// Request opcodes
	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_QUERY   = 2'd2,
		OP_RELEASE = 2'd3
	} op_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_NO_MEM     = 3'd1,
		ST_NULL       = 3'd2,
		ST_UNALIGNED  = 3'd3,
		ST_RANGE      = 3'd4,
		ST_RESERVED   = 3'd5,
		ST_DOUBLE     = 3'd6
	} status_t;

	localparam int ADDR_W     = 28;
	localparam int CNT_W      = 17;
	localparam int WORD_BITS  = 64;
	localparam int WB_W       = 6;
	localparam logic [CNT_W-1:0] RESERVED_RESET = 17'd18432;

	// Register addresses (byte offsets)
	localparam logic [3:0] REG_TRACKED  = 4'd0;
	localparam logic [3:0] REG_ACTIVE   = 4'd4;
	localparam logic [3:0] REG_RESERVED = 4'd8;

	// Classified request control from front to back
	typedef struct packed {
		op_t     op;
		status_t status;
	} cmd_ctl_t;

	// One result item
	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] page_address;
		logic              owned;
		logic [CNT_W-1:0]  used_count;
	} res_t;

	// Lowest set bit of a map word
	function automatic logic [WB_W-1:0] first_set(input logic [WORD_BITS-1:0] v);
		logic [WB_W-1:0] r;
		r = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) r = WB_W'(i);
		end
		return r;
	endfunction

endpackage

// ===== hdl/bpa_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bpa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/bpa_fifo.sv =====
// Small register queue used between the allocator stages.
// No dependencies.
module bpa_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] ent_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = ent_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) ent_q[wr_q] <= din;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== hdl/bpa_front.sv =====
// Front stage: takes requests, checks addresses and queues classified commands.
// Depends on bpa_pkg and bpa_fifo.
module bpa_front import bpa_pkg::*; #(
	parameter int PAGE_SHIFT = 12,
	parameter int PGW        = 16,
	parameter int CW         = 17
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [1:0]        opcode,
	input  logic [ADDR_W-1:0] address,
	output logic              full,
	input  logic              blocked,
	input  logic [CW-1:0]     eff_trk,
	input  logic [CNT_W-1:0]  reserved,
	input  logic              cmd_pop,
	output logic              cmd_empty,
	output cmd_ctl_t          cmd_ctl,
	output logic [PGW-1:0]    cmd_page
);

	localparam int PFW = ADDR_W - PAGE_SHIFT;
	localparam int XW  = (CW > PFW) ? CW : PFW;
	localparam int FW  = $bits(cmd_ctl_t) + PGW;

	logic [PFW-1:0] pg;
	cmd_ctl_t       ctl;
	logic           q_full;
	logic [FW-1:0]  q_out;

	assign pg = address[ADDR_W-1:PAGE_SHIFT];

	// classify: validation order null, unaligned, range, reserved
	always_comb begin
		ctl.op     = op_t'(opcode);
		ctl.status = ST_OK;
		if (ctl.op != OP_ALLOC) begin
			if (address == '0)
				ctl.status = ST_NULL;
			else if (address[PAGE_SHIFT-1:0] != '0)
				ctl.status = ST_UNALIGNED;
			else if (XW'(pg) >= XW'(eff_trk))
				ctl.status = ST_RANGE;
			else if (ctl.op != OP_QUERY && XW'(pg) < XW'(reserved))
				ctl.status = ST_RESERVED;
		end
	end

	assign full = q_full || blocked;

	bpa_fifo #(.WIDTH(FW), .DEPTH(2)) u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push && !full),
		.din   ({ctl, PGW'(pg)}),
		.full  (q_full),
		.pop   (cmd_pop),
		.dout  (q_out),
		.empty (cmd_empty)
	);

	assign cmd_ctl  = q_out[FW-1:PGW];
	assign cmd_page = q_out[PGW-1:0];

endmodule

// ===== hdl/bpa_back.sv =====
// Back stage: owns the used-bit map, scans for allocs, applies frees and queries.
// Depends on bpa_pkg and bpa_ram.
module bpa_back import bpa_pkg::*; #(
	parameter int NUM_PAGES  = 65536,
	parameter int PAGE_SHIFT = 12,
	parameter int DEPTH      = 1024,
	parameter int WIW        = 10,
	parameter int PGW        = 16,
	parameter int CW         = 17
) (
	input  logic           clk,
	input  logic           arst_n,
	output logic           clearing,
	input  logic           cmd_empty,
	output logic           cmd_pop,
	input  cmd_ctl_t       cmd_ctl,
	input  logic [PGW-1:0] cmd_page,
	input  logic [CW-1:0]  eff_act,
	input  logic           hint_ld,
	input  logic [CW-1:0]  hint_val,
	input  logic           res_full,
	output logic           res_push,
	output res_t           res
);

	typedef enum logic [6:0] {
		S_CLEAR    = 7'b0000001,
		S_IDLE     = 7'b0000010,
		S_RD       = 7'b0000100,
		S_EXEC     = 7'b0001000,
		S_SCAN_RD  = 7'b0010000,
		S_SCAN_CHK = 7'b0100000,
		S_DONE     = 7'b1000000
	} state_t;

	state_t                 state_q;
	cmd_ctl_t               ctl_q;
	logic [PGW-1:0]         page_q;
	logic [WIW-1:0]         cw_q;
	logic [CW-1:0]          lo_q, hi_q, hint_q, used_q;
	logic                   phase_q;
	res_t                   res_q;

	logic                   ram_we;
	logic [WIW-1:0]         ram_waddr, ram_raddr;
	logic [WORD_BITS-1:0]   ram_wdata, rdata;

	logic                   bit_used;
	logic [WORD_BITS-1:0]   lo_mask, hi_mask, cand, page_bit;
	logic [WB_W-1:0]        fb;
	logic [PGW-1:0]         found_pg;
	logic [CW-1:0]          next_base, used_inc, used_dec;

	bpa_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH), .AW(WIW)) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	// bit test and scan word evaluation
	assign page_bit  = WORD_BITS'(1) << page_q[WB_W-1:0];
	assign bit_used  = |(rdata & page_bit);
	assign lo_mask   = (lo_q[PGW-1:WB_W] == cw_q) ? ('1 << lo_q[WB_W-1:0]) : '1;
	assign hi_mask   = (hi_q[CW-1:WB_W] == (CW-WB_W)'(cw_q)) ? ~('1 << hi_q[WB_W-1:0]) : '1;
	assign cand      = ~rdata & lo_mask & hi_mask;
	assign fb        = first_set(cand);
	assign found_pg  = {cw_q, fb};
	assign next_base = CW'({(WIW+1)'(cw_q) + 1'b1, {WB_W{1'b0}}});
	assign used_inc  = (used_q < CW'(NUM_PAGES)) ? used_q + 1'b1 : used_q;
	assign used_dec  = (used_q != '0) ? used_q - 1'b1 : used_q;

	// map port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cw_q;
		ram_wdata = '1;
		ram_raddr = cw_q;
		case (state_q)
			S_CLEAR: ram_we = 1'b1;
			S_RD:    ram_raddr = page_q[PGW-1:WB_W];
			S_EXEC: begin
				ram_waddr = page_q[PGW-1:WB_W];
				ram_wdata = rdata & ~page_bit;
				ram_we    = bit_used && (ctl_q.op == OP_FREE || ctl_q.op == OP_RELEASE);
			end
			S_SCAN_CHK: begin
				ram_wdata = rdata | (WORD_BITS'(1) << fb);
				ram_we    = (cand != '0);
			end
			default: ;
		endcase
	end

	assign clearing = (state_q == S_CLEAR);
	assign cmd_pop  = (state_q == S_IDLE) && !cmd_empty;
	assign res_push = (state_q == S_DONE) && !res_full;
	assign res      = res_q;

	// payload of the current request
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			ctl_q  <= cmd_ctl;
			page_q <= cmd_page;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cw_q    <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			phase_q <= 1'b0;
			hint_q  <= CW'(RESERVED_RESET);
			used_q  <= CW'(NUM_PAGES);
			res_q   <= '0;
		end else begin
			if (hint_ld) hint_q <= hint_val;
			case (state_q)
				// fill the map with ones, one word per cycle
				S_CLEAR: begin
					cw_q <= cw_q + 1'b1;
					if (cw_q == WIW'(DEPTH - 1)) begin
						cw_q    <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (!cmd_empty) begin
						res_q.status       <= ST_OK;
						res_q.page_address <= '0;
						res_q.owned        <= 1'b0;
						res_q.used_count   <= used_q[CNT_W-1:0];
						if (cmd_ctl.op == OP_ALLOC) begin
							if (hint_q < eff_act) begin
								lo_q    <= hint_q;
								phase_q <= 1'b0;
								cw_q    <= hint_q[PGW-1:WB_W];
							end else begin
								lo_q    <= '0;
								phase_q <= 1'b1;
								cw_q    <= '0;
							end
							hi_q    <= eff_act;
							state_q <= S_SCAN_RD;
						end else if (cmd_ctl.status != ST_OK) begin
							if (cmd_ctl.op != OP_QUERY) res_q.status <= cmd_ctl.status;
							state_q <= S_DONE;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: state_q <= S_EXEC;
				// apply free, release or query on the fetched word
				S_EXEC: begin
					case (ctl_q.op)
						OP_FREE: begin
							if (bit_used) begin
								used_q                <= used_dec;
								res_q.used_count      <= used_dec[CNT_W-1:0];
								if (CW'(page_q) < hint_q) hint_q <= CW'(page_q);
							end else begin
								res_q.status <= ST_DOUBLE;
							end
						end
						OP_RELEASE: begin
							if (bit_used) begin
								used_q           <= used_dec;
								res_q.used_count <= used_dec[CNT_W-1:0];
								if (CW'(page_q) < hint_q) hint_q <= CW'(page_q);
							end
						end
						OP_QUERY: res_q.owned <= bit_used;
						default: ;
					endcase
					state_q <= S_DONE;
				end
				// range bookkeeping, then read next word
				S_SCAN_RD: begin
					if (lo_q >= hi_q) begin
						if (!phase_q) begin
							phase_q <= 1'b1;
							lo_q    <= '0;
							hi_q    <= hint_q;
							cw_q    <= '0;
						end else begin
							res_q.status <= ST_NO_MEM;
							state_q      <= S_DONE;
						end
					end else begin
						state_q <= S_SCAN_CHK;
					end
				end
				S_SCAN_CHK: begin
					if (cand != '0) begin
						used_q             <= used_inc;
						res_q.used_count   <= used_inc[CNT_W-1:0];
						hint_q             <= CW'(found_pg) + 1'b1;
						res_q.page_address <= ADDR_W'({found_pg, {PAGE_SHIFT{1'b0}}});
						state_q            <= S_DONE;
					end else begin
						if (next_base < hi_q) cw_q <= cw_q + 1'b1;
						else                  lo_q <= hi_q;
						state_q <= S_SCAN_RD;
					end
				end
				S_DONE: if (!res_full) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/bitmap_page_allocator_top.sv =====
// Bitmap page allocator: next-fit alloc, free, query and release over a used-bit map.
// Path: error requests go from IDLE to DONE; free, query and release pass RD and EXEC; alloc
// loops SCAN_RD, SCAN_CHK per map word. No new request is taken until DONE pushes the result.
// Reset: async, active low; a clearing pass writes every map word and marks every page used,
// and no request is taken until it ends. Registers reset to 65536, 65536, 18432.
// Depends on bpa_pkg, bpa_front, bpa_back, bpa_fifo.
module bitmap_page_allocator_top import bpa_pkg::*; #(
	parameter int NUM_PAGES  = 65536,
	parameter int PAGE_SHIFT = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        opcode,
	input  logic [ADDR_W-1:0] address,
	output logic              empty,
	input  logic              pop,
	output logic [2:0]        status,
	output logic [ADDR_W-1:0] page_address,
	output logic              owned,
	output logic [CNT_W-1:0]  used_count,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int DEPTH = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int WIW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PGW   = WIW + WB_W;
	localparam int CW    = (PGW + 1 > CNT_W) ? PGW + 1 : CNT_W;

	logic [CNT_W-1:0] tracked_q, active_q, reserved_q;
	logic [CW-1:0]    eff_trk, eff_act;
	logic             wr_en;
	logic             clearing, cmd_empty, cmd_pop, res_full, res_push;
	cmd_ctl_t         cmd_ctl;
	logic [PGW-1:0]   cmd_page;
	res_t             res_in, res_out;

	// configuration registers
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracked_q  <= 17'd65536;
			active_q   <= 17'd65536;
			reserved_q <= RESERVED_RESET;
		end else if (wr_en) begin
			case (paddr)
				REG_TRACKED:  tracked_q  <= pwdata[CNT_W-1:0];
				REG_ACTIVE:   active_q   <= pwdata[CNT_W-1:0];
				REG_RESERVED: reserved_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			REG_TRACKED:  prdata = 32'(tracked_q);
			REG_ACTIVE:   prdata = 32'(active_q);
			REG_RESERVED: prdata = 32'(reserved_q);
			default:      prdata = '0;
		endcase
	end

	// limits capped at map size
	assign eff_trk = (CW'(tracked_q) < CW'(NUM_PAGES)) ? CW'(tracked_q) : CW'(NUM_PAGES);
	assign eff_act = (CW'(active_q) < eff_trk) ? CW'(active_q) : eff_trk;

	bpa_front #(.PAGE_SHIFT(PAGE_SHIFT), .PGW(PGW), .CW(CW)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.opcode   (opcode),
		.address  (address),
		.full     (full),
		.blocked  (clearing),
		.eff_trk  (eff_trk),
		.reserved (reserved_q),
		.cmd_pop  (cmd_pop),
		.cmd_empty(cmd_empty),
		.cmd_ctl  (cmd_ctl),
		.cmd_page (cmd_page)
	);

	bpa_back #(
		.NUM_PAGES(NUM_PAGES), .PAGE_SHIFT(PAGE_SHIFT), .DEPTH(DEPTH),
		.WIW(WIW), .PGW(PGW), .CW(CW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.clearing (clearing),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.cmd_ctl  (cmd_ctl),
		.cmd_page (cmd_page),
		.eff_act  (eff_act),
		.hint_ld  (wr_en && paddr == REG_RESERVED),
		.hint_val (CW'(pwdata[CNT_W-1:0])),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_in)
	);

	// result queue
	bpa_fifo #(.WIDTH($bits(res_t)), .DEPTH(2)) u_resq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.din   (res_in),
		.full  (res_full),
		.pop   (pop),
		.dout  (res_out),
		.empty (empty)
	);

	assign status       = res_out.status;
	assign page_address = res_out.page_address;
	assign owned        = res_out.owned;
	assign used_count   = res_out.used_count;

endmodule

// ===== tb/bpa_checker.sv =====
// Checker for the bitmap page allocator: tracks register writes, predicts each result
// from a private copy of the used map and compares accepted results in order.
// Depends on bpa_pkg.
module bpa_checker import bpa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              full,
	input  logic [1:0]        opcode,
	input  logic [ADDR_W-1:0] address,
	input  logic              empty,
	input  logic              pop,
	input  logic [2:0]        status,
	input  logic [ADDR_W-1:0] page_address,
	input  logic              owned,
	input  logic [CNT_W-1:0]  used_count,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	output int                errors,
	output int                pending
);
	localparam int MAP_PAGES = 65536;
	localparam int PG_SHIFT  = 12;

	// Private model state
	bit [MAP_PAGES-1:0] page_used;
	int unsigned        next_hint;
	int unsigned        pages_used;
	int unsigned        cfg_tracked;
	int unsigned        cfg_active;
	int unsigned        cfg_reserved;
	res_t               expected_q[$];

	assign pending = expected_q.size();

	function automatic int unsigned tracked_limit();
		return (cfg_tracked < MAP_PAGES) ? cfg_tracked : MAP_PAGES;
	endfunction

	// Common validation for free and release
	function automatic status_t validate_page(input logic [ADDR_W-1:0] a, output int unsigned pg);
		pg = a >> PG_SHIFT;
		if (a == '0) return ST_NULL;
		if (a[PG_SHIFT-1:0] != '0) return ST_UNALIGNED;
		if (pg >= tracked_limit()) return ST_RANGE;
		if (pg < cfg_reserved) return ST_RESERVED;
		return ST_OK;
	endfunction

	task automatic give_back(input int unsigned pg);
		page_used[pg] = 1'b0;
		if (pages_used > 0) pages_used--;
		if (pg < next_hint) next_hint = pg;
	endtask

	// Work out the result of one request and advance the model
	task automatic predict_request(input op_t op, input logic [ADDR_W-1:0] a, output res_t r);
		int unsigned lim, lap_lim, pg;
		bit          hit;
		r = '0;
		r.status = ST_OK;
		case (op)
			OP_ALLOC: begin
				lim = (cfg_active < tracked_limit()) ? cfg_active : tracked_limit();
				lap_lim = (next_hint < lim) ? next_hint : lim;
				hit = 0;
				for (int unsigned i = next_hint; i < lim && !hit; i++)
					if (!page_used[i]) begin pg = i; hit = 1; end
				for (int unsigned i = 0; i < lap_lim && !hit; i++)
					if (!page_used[i]) begin pg = i; hit = 1; end
				if (hit) begin
					page_used[pg] = 1'b1;
					if (pages_used < MAP_PAGES) pages_used++;
					next_hint = pg + 1;
					r.page_address = ADDR_W'(pg << PG_SHIFT);
				end else begin
					r.status = ST_NO_MEM;
				end
			end
			OP_FREE: begin
				r.status = validate_page(a, pg);
				if (r.status == ST_OK) begin
					if (!page_used[pg]) r.status = ST_DOUBLE;
					else give_back(pg);
				end
			end
			OP_QUERY: begin
				pg = a >> PG_SHIFT;
				if (a != '0 && a[PG_SHIFT-1:0] == '0 && pg < tracked_limit() && page_used[pg])
					r.owned = 1'b1;
			end
			default: begin
				r.status = validate_page(a, pg);
				if (r.status == ST_OK && page_used[pg]) give_back(pg);
			end
		endcase
		r.used_count = CNT_W'(pages_used);
	endtask

	// Watch config writes, requests and results
	always @(posedge clk or negedge arst_n) begin
		res_t r, want;
		if (!arst_n) begin
			page_used    = '1;
			next_hint    = RESERVED_RESET;
			pages_used   = MAP_PAGES;
			cfg_tracked  = 65536;
			cfg_active   = 65536;
			cfg_reserved = RESERVED_RESET;
			expected_q.delete();
			errors = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					REG_TRACKED: cfg_tracked = pwdata[CNT_W-1:0];
					REG_ACTIVE:  cfg_active = pwdata[CNT_W-1:0];
					REG_RESERVED: begin
						cfg_reserved = pwdata[CNT_W-1:0];
						next_hint = pwdata[CNT_W-1:0];
					end
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (expected_q.size() == 0) begin
					$error("result with no request outstanding");
					errors++;
				end else begin
					want = expected_q.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						errors++;
					end
					if (page_address !== want.page_address) begin
						$error("page_address: expected %h, got %h", want.page_address, page_address);
						errors++;
					end
					if (owned !== want.owned) begin
						$error("owned: expected %0d, got %0d", want.owned, owned);
						errors++;
					end
					if (used_count !== want.used_count) begin
						$error("used_count: expected %0d, got %0d", want.used_count, used_count);
						errors++;
					end
				end
			end
			if (push && !full) begin
				predict_request(op_t'(opcode), address, r);
				expected_q.push_back(r);
			end
		end
	end

endmodule

// ===== tb/bitmap_page_allocator_top_test.sv =====
// Testbench top for the bitmap page allocator: clock, reset, register phases,
// directed and random requests, result draining and the verdict.
// Depends on bpa_pkg, bitmap_page_allocator_top and bpa_checker.
module bitmap_page_allocator_top_test;
	import bpa_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              push;
	logic              full;
	logic [1:0]        opcode;
	logic [ADDR_W-1:0] address;
	logic              empty;
	logic              pop;
	logic [2:0]        status;
	logic [ADDR_W-1:0] page_address;
	logic              owned;
	logic [CNT_W-1:0]  used_count;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [3:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	int                errors;
	int                pending;
	int unsigned       cur_tracked;
	int unsigned       cur_reserved;
	bit                burst_mode;

	bitmap_page_allocator_top uut (.*);

	bpa_checker chk (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .opcode(opcode),
		.address(address), .empty(empty), .pop(pop), .status(status),
		.page_address(page_address), .owned(owned), .used_count(used_count),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Mostly short gaps, a few long ones, none in burst stretches
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst_mode || r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Flip between idling and burst stretches
	always begin
		burst_mode = 1'b0;
		repeat ($urandom_range(100, 400)) @(posedge clk);
		burst_mode = 1'b1;
		repeat ($urandom_range(50, 200)) @(posedge clk);
	end

	// Result side: random stalls
	initial begin
		int gap;
		pop = 1'b0;
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	task automatic send_request(input op_t op, input logic [ADDR_W-1:0] a);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push    <= 1'b1;
		opcode  <= op;
		address <= a;
		do @(posedge clk); while (full);
	endtask

	// Register writes only with nothing in flight
	task automatic write_reg(input logic [3:0] ra, input int unsigned v);
		push <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (8) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ra;
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_layout(input int unsigned trk, input int unsigned act,
			input int unsigned rsv);
		write_reg(REG_TRACKED, trk);
		write_reg(REG_ACTIVE, act);
		write_reg(REG_RESERVED, rsv);
		cur_tracked  = trk;
		cur_reserved = rsv;
	endtask

	function automatic logic [ADDR_W-1:0] page_addr(input int unsigned pg);
		return ADDR_W'(pg << 12);
	endfunction

	// Mostly aligned pages near the tracked range, some malformed addresses
	function automatic logic [ADDR_W-1:0] pick_address();
		int unsigned pg, r;
		r = $urandom_range(0, 99);
		if (r < 85) begin
			pg = $urandom_range(0, cur_tracked + 4);
			if (pg > 65535) pg = 65535;
			return page_addr(pg);
		end
		if (r < 92) return ADDR_W'($urandom());
		if (r < 97) return page_addr($urandom_range(0, 65535)) | ADDR_W'($urandom_range(1, 4095));
		return '0;
	endfunction

	function automatic op_t pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) return OP_ALLOC;
		if (r < 65) return OP_FREE;
		if (r < 80) return OP_QUERY;
		return OP_RELEASE;
	endfunction

	// One phase: hand back a run of pages, then random traffic
	task automatic run_phase(input int n_release, input int n_random);
		for (int i = 0; i < n_release; i++)
			send_request(OP_RELEASE, page_addr(cur_reserved + i));
		for (int i = 0; i < n_random; i++)
			send_request(pick_op(), pick_address());
	endtask

	initial begin
		arst_n  = 1'b0;
		push    = 1'b0;
		opcode  = OP_ALLOC;
		address = '0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		cur_tracked  = 65536;
		cur_reserved = 18432;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset layout, every page used
		send_request(OP_ALLOC, '0);
		send_request(OP_FREE, '0);
		send_request(OP_FREE, 28'h4800001);
		send_request(OP_FREE, page_addr(5));
		send_request(OP_RELEASE, page_addr(20000));
		send_request(OP_RELEASE, page_addr(20000));
		send_request(OP_FREE, page_addr(20000));
		send_request(OP_QUERY, page_addr(20000));
		send_request(OP_QUERY, '0);
		send_request(OP_QUERY, 28'h0000FFF);
		send_request(OP_QUERY, 28'hFFFF000);
		send_request(OP_ALLOC, 28'hFFFFFFF);
		send_request(OP_FREE, page_addr(20000));
		send_request(OP_RELEASE, 28'hFFFF000);
		send_request(OP_ALLOC, '0);
		send_request(OP_ALLOC, '0);
		send_request(OP_RELEASE, 28'hFFFFFFF);
		send_request(OP_QUERY, page_addr(18432));

		// Directed: out of range, empty active range, hint past active
		set_layout(1, 0, 0);
		send_request(OP_RELEASE, page_addr(1));
		send_request(OP_FREE, page_addr(0));
		send_request(OP_ALLOC, '0);
		send_request(OP_QUERY, page_addr(1));
		set_layout(512, 100, 200);
		run_phase(4, 0);
		send_request(OP_ALLOC, '0);
		send_request(OP_RELEASE, page_addr(50));

		// Random phases, small maps mostly
		set_layout(256, 256, 16);
		run_phase(40, 250);
		set_layout(128, 128, 0);
		run_phase(60, 250);
		set_layout(1000, 300, 64);
		run_phase(30, 250);
		set_layout(65536, 192, 0);
		run_phase(40, 250);
		set_layout(64, 64, 8);
		run_phase(20, 200);
		set_layout(65536, 65536, 65536);
		run_phase(2, 30);
		set_layout(2048, 1024, 1000);
		run_phase(30, 120);

		push <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#(12 * 30000000);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
